// File: src/utf16le_to_utf8_transcoder_core_assert.svh
// assertion macros used by the checker file of the transcoder
// no dependencies; include by bare file name
`ifndef UTF16LE_TO_UTF8_TRANSCODER_CORE_ASSERT_SVH
`define UTF16LE_TO_UTF8_TRANSCODER_CORE_ASSERT_SVH

// property checked outside reset
`define U16U8_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("transcoder assertion failed");

// property checked at every edge, reset included
`define U16U8_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("transcoder assertion failed");

`endif

// File: src/u16u8_pkg.sv
// types, constants and utf-8 byte functions of the utf-16 to utf-8 transcoder
// no dependencies
`timescale 1ns / 1ps

package u16u8_pkg;

   localparam logic [15:0] NUL_UNIT    = 16'h0000;
   localparam logic [15:0] HIGH_FIRST  = 16'hD800;
   localparam logic [15:0] HIGH_LAST   = 16'hDBFF;
   localparam logic [15:0] LOW_FIRST   = 16'hDC00;
   localparam logic [15:0] LOW_LAST    = 16'hDFFF;
   localparam logic [15:0] REPLACEMENT = 16'hFFFD;
   localparam logic [20:0] PAIR_BASE   = 21'h010000;
   localparam logic [20:0] LIMIT_1B    = 21'h000080;
   localparam logic [20:0] LIMIT_2B    = 21'h000800;
   localparam logic [20:0] LIMIT_3B    = 21'h010000;

   // work for the back part: up to two code points, then maybe the end marker
   typedef struct packed {
      logic        cp0_vld;
      logic [20:0] cp0;
      logic        cp1_vld;
      logic [15:0] cp1;
      logic        str_end;
   } job_type;

   typedef struct packed {
      logic    vld;
      job_type job;
   } push_type;

   typedef struct packed {
      logic    vld;
      job_type job;
   } head_type;

   typedef enum logic [1:0] {
      PH_CP0,
      PH_CP1,
      PH_END
   } phase_type;

   // number of utf-8 bytes minus one
   function automatic logic [1:0] utf8_len_m1(input logic [20:0] cp);
      logic [1:0] len_m1;
      if (cp < LIMIT_1B) begin
         len_m1 = 2'd0;
      end else if (cp < LIMIT_2B) begin
         len_m1 = 2'd1;
      end else if (cp < LIMIT_3B) begin
         len_m1 = 2'd2;
      end else begin
         len_m1 = 2'd3;
      end
      return len_m1;
   endfunction

   function automatic logic [7:0] utf8_byte(input logic [20:0] cp,
                                            input logic [1:0]  len_m1,
                                            input logic [1:0]  idx);
      logic [7:0] b;
      b = 8'h00;
      case (len_m1)
         2'd0: b = {1'b0, cp[6:0]};
         2'd1: begin
            case (idx)
               2'd0:    b = {3'b110, cp[10:6]};
               default: b = {2'b10, cp[5:0]};
            endcase
         end
         2'd2: begin
            case (idx)
               2'd0:    b = {4'b1110, cp[15:12]};
               2'd1:    b = {2'b10, cp[11:6]};
               default: b = {2'b10, cp[5:0]};
            endcase
         end
         default: begin
            case (idx)
               2'd0:    b = {5'b11110, cp[20:18]};
               2'd1:    b = {2'b10, cp[17:12]};
               2'd2:    b = {2'b10, cp[11:6]};
               default: b = {2'b10, cp[5:0]};
            endcase
         end
      endcase
      return b;
   endfunction

endpackage

// File: src/u16u8_if.sv
// request and response channel interfaces of the transcoder
// no dependencies
`timescale 1ns / 1ps

interface u16u8_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] code_unit;
   logic        last_unit;

   modport source (output valid, output code_unit, output last_unit, input ready);
   modport sink   (input valid, input code_unit, input last_unit, output ready);
endinterface

interface u16u8_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       has_byte;
   logic       string_end;

   modport source (output valid, output out_byte, output has_byte, output string_end,
                   input ready);
   modport sink   (input valid, input out_byte, input has_byte, input string_end,
                   output ready);
endinterface

// File: src/u16u8_front.sv
// front part: takes code units, pairs surrogates, tracks nul stop, builds jobs
// depends on u16u8_pkg and u16u8_if
`timescale 1ns / 1ps

module u16u8_front import u16u8_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   u16u8_req_if.sink    req_chan,
   input  logic         q_full,
   output push_type     push
);

   logic       pending_ff, pending_in;
   logic       stopped_ff, stopped_in;
   logic [9:0] held_ff, held_in;
   logic       accept;
   logic       pair_done;
   logic [15:0] u;
   job_type    job;

   assign req_chan.ready = !q_full;
   assign accept         = req_chan.valid && !q_full;
   assign u              = req_chan.code_unit;

   always_comb begin
      job        = '0;
      pending_in = pending_ff;
      stopped_in = stopped_ff;
      held_in    = held_ff;
      pair_done  = 1'b0;
      if (!stopped_ff) begin
         if (pending_ff) begin
            pending_in  = 1'b0;
            job.cp0_vld = 1'b1;
            if (u inside {[LOW_FIRST:LOW_LAST]}) begin
               job.cp0   = PAIR_BASE + {1'b0, held_ff, u[9:0]};
               pair_done = 1'b1;
            end else begin
               job.cp0 = {5'd0, REPLACEMENT};
            end
         end
         if (!pair_done) begin
            if (u == NUL_UNIT) begin
               stopped_in = 1'b1;
            end else if (u inside {[HIGH_FIRST:HIGH_LAST]}) begin
               if (req_chan.last_unit) begin
                  job.cp1_vld = 1'b1;
                  job.cp1     = REPLACEMENT;
               end else begin
                  held_in    = u[9:0];
                  pending_in = 1'b1;
               end
            end else if (u inside {[LOW_FIRST:LOW_LAST]}) begin
               job.cp1_vld = 1'b1;
               job.cp1     = REPLACEMENT;
            end else begin
               job.cp1_vld = 1'b1;
               job.cp1     = u;
            end
         end
      end
      if (req_chan.last_unit) begin
         job.str_end = 1'b1;
         pending_in  = 1'b0;
         stopped_in  = 1'b0;
      end
      push.vld = accept && (job.cp0_vld || job.cp1_vld || job.str_end);
      push.job = job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b0;
         stopped_ff <= 1'b0;
      end else if (accept) begin
         pending_ff <= pending_in;
         stopped_ff <= stopped_in;
      end
   end

   // only read while a high surrogate is pending
   always_ff @(posedge clock) begin
      if (accept) begin
         held_ff <= held_in;
      end
   end

endmodule

// File: src/u16u8_queue.sv
// short job queue between front and back parts
// depends on u16u8_pkg
`timescale 1ns / 1ps

module u16u8_queue import u16u8_pkg::*; #(
   parameter int DEPTH = 2
) (
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   output logic     full,
   output head_type head,
   input  logic     pop
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full     = count_ff == CNT_W'(DEPTH);
   assign head.vld = count_ff != '0;
   assign head.job = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push.vld && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push.vld) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push.vld) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push.vld) begin
         mem_ff[wr_ptr_ff] <= push.job;
      end
   end

endmodule

// File: src/u16u8_back.sv
// back part: walks the head job and sends one utf-8 byte or end marker per cycle
// while the response channel is not stalled; depends on u16u8_pkg and u16u8_if
`timescale 1ns / 1ps

module u16u8_back import u16u8_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  head_type      head,
   output logic          pop,
   u16u8_rsp_if.source   rsp_chan
);

   phase_type   phase_ff, phase_in;
   logic [1:0]  idx_ff, idx_in;
   logic        rsp_valid_ff;
   logic [7:0]  out_byte_ff, out_byte_in;
   logic        has_byte_ff, has_byte_in;
   logic        string_end_ff, string_end_in;

   logic        use_cp0, use_cp1, is_cp;
   logic [20:0] cur_cp;
   logic [1:0]  len_m1;
   logic        elem_last, remain, advance, step;

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.out_byte   = out_byte_ff;
   assign rsp_chan.has_byte   = has_byte_ff;
   assign rsp_chan.string_end = string_end_ff;

   always_comb begin
      use_cp0   = (phase_ff == PH_CP0) && head.job.cp0_vld;
      use_cp1   = !use_cp0 && (phase_ff != PH_END) && head.job.cp1_vld;
      is_cp     = use_cp0 || use_cp1;
      cur_cp    = use_cp0 ? head.job.cp0 : {5'd0, head.job.cp1};
      len_m1    = utf8_len_m1(cur_cp);
      elem_last = !is_cp || (idx_ff == len_m1);
      remain    = use_cp0 ? (head.job.cp1_vld || head.job.str_end) :
                  use_cp1 ? head.job.str_end : 1'b0;
      advance   = !rsp_valid_ff || rsp_chan.ready;
      step      = advance && head.vld;
      pop       = step && elem_last && !remain;

      out_byte_in   = is_cp ? utf8_byte(cur_cp, len_m1, idx_ff) : 8'h00;
      has_byte_in   = is_cp;
      string_end_in = !is_cp;

      phase_in = phase_ff;
      idx_in   = idx_ff;
      if (step) begin
         if (!elem_last) begin
            idx_in = idx_ff + 2'd1;
         end else begin
            idx_in = 2'd0;
            if (!remain) begin
               phase_in = PH_CP0;
            end else begin
               case (phase_ff)
                  PH_CP0:  phase_in = use_cp0 ? PH_CP1 : PH_END;
                  PH_CP1:  phase_in = PH_END;
                  default: phase_in = PH_END;
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_CP0;
         idx_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         idx_ff   <= idx_in;
         if (advance) begin
            rsp_valid_ff <= head.vld;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_byte_ff   <= out_byte_in;
         has_byte_ff   <= has_byte_in;
         string_end_ff <= string_end_in;
      end
   end

endmodule

// File: src/utf16le_to_utf8_transcoder_core.sv
// top level of the utf-16le to utf-8 transcoder
// depends on u16u8_pkg, u16u8_if, u16u8_front, u16u8_queue, u16u8_back
//
//   channel   dir  payload                             meaning
//   req_chan  in   code_unit[15:0], last_unit          one utf-16 unit per request
//   rsp_chan  out  out_byte[7:0], has_byte, string_end  one utf-8 byte or end marker
//
// a unit is taken in the cycle it arrives whenever the job queue has room
// each unit gives 0 to 7 responses (up to two 3-byte sequences plus end marker)
// the back part sends one response per cycle while the response channel is not
// stalled; a non-ascii bmp unit gives two or three bytes, a low surrogate
// closing a pair gives four
// reset is synchronous; it empties the queue and drops any held surrogate
// a stalled response holds in the output register while the front keeps filling
`timescale 1ns / 1ps

module utf16le_to_utf8_transcoder_core import u16u8_pkg::*; #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic         clock,
   input  logic         reset,
   u16u8_req_if.sink    req_chan,
   u16u8_rsp_if.source  rsp_chan
);

   // front to queue
   push_type push;
   logic     q_full;
   // queue to back
   head_type head;
   logic     pop;

   // classification: surrogate pairing, nul stop, end of field
   u16u8_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_full   (q_full),
      .push     (push)
   );

   // decouples unit intake from byte output
   u16u8_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (q_full),
      .head  (head),
      .pop   (pop)
   );

   // byte serializer with output register
   u16u8_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

// File: src/u16u8_checker.sv
// port-level checks of the transcoder, bound to the top level
// depends on utf16le_to_utf8_transcoder_core_assert.svh
`timescale 1ns / 1ps
`include "utf16le_to_utf8_transcoder_core_assert.svh"

module u16u8_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] out_byte,
   input logic       has_byte,
   input logic       string_end
);

   property p_rsp_hold;
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(out_byte) && $stable(has_byte) && $stable(string_end);
   endproperty

   // stalled response keeps its payload
   `U16U8_ASSERT(a_rsp_hold, clock, reset, p_rsp_hold)

   // a response is either a byte or the end marker
   `U16U8_ASSERT(a_rsp_kind, clock, reset, rsp_valid |-> has_byte != string_end)

   // end marker carries a zero byte
   `U16U8_ASSERT(a_marker_zero, clock, reset, rsp_valid && string_end |-> out_byte == 8'h00)

   // nothing offered right after reset
   `U16U8_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_valid)

endmodule

bind utf16le_to_utf8_transcoder_core u16u8_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .out_byte   (rsp_chan.out_byte),
   .has_byte   (rsp_chan.has_byte),
   .string_end (rsp_chan.string_end)
);
